// File: hdl/aabb_pkg.sv
// Shared types and constants for the box transform pipeline.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int COORD_W = 24;              // signed Q16.8 coordinate
  localparam int COEF_W  = 16;              // signed fixed-point coefficient
  localparam int ROW_W   = 3 * COEF_W;      // one packed matrix row
  localparam int AXES    = 3;
  localparam int PROD_W  = COORD_W + COEF_W;  // one coefficient times one coordinate
  localparam int ACC_W   = PROD_W + 2;        // sum of three products plus rounding
  localparam int VAL_W   = ACC_W + 1;         // rounded sum plus translation

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Register map, index = byte address / 8
  typedef enum logic [2:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } reg_idx_t;

  typedef logic [COORD_W-1:0] coord_t;

  // Box corners; index 0 = x. Lower corner sits in the low bits.
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] hi;
    logic [AXES-1:0][COORD_W-1:0] lo;
  } box_t;

  // Live configuration
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] shift;
    logic [AXES-1:0][ROW_W-1:0]   row;
  } cfg_t;

  // Products per [output axis][input axis], for the lower and upper input bound
  typedef struct packed {
    logic [AXES-1:0][AXES-1:0][PROD_W-1:0] hi;
    logic [AXES-1:0][AXES-1:0][PROD_W-1:0] lo;
  } prod_set_t;

  // Extreme accumulated sums per output axis, rounding offset already added
  typedef struct packed {
    logic [AXES-1:0][ACC_W-1:0] amax;
    logic [AXES-1:0][ACC_W-1:0] amin;
  } acc_span_t;

endpackage

// File: hdl/aabb_cfg_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on aabb_pkg for the register map and cfg_t.
`timescale 1ns / 1ps

module aabb_cfg_regs
  import aabb_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output cfg_t        cfg
);

  localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << COEF_FRAC_BITS;

  logic     wr;
  reg_idx_t idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[5:3]);

  // Register writes; reset gives the identity map
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= ONE;
      cfg.row[1] <= ONE << COEF_W;
      cfg.row[2] <= ONE << (2 * COEF_W);
      cfg.shift  <= '0;
    end else if (wr) begin
      case (idx)
        REG_ROW_X:   cfg.row[0]   <= pwdata[ROW_W-1:0];
        REG_ROW_Y:   cfg.row[1]   <= pwdata[ROW_W-1:0];
        REG_ROW_Z:   cfg.row[2]   <= pwdata[ROW_W-1:0];
        REG_SHIFT_X: cfg.shift[0] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y: cfg.shift[1] <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z: cfg.shift[2] <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ROW_X:   prdata = 64'(cfg.row[0]);
      REG_ROW_Y:   prdata = 64'(cfg.row[1]);
      REG_ROW_Z:   prdata = 64'(cfg.row[2]);
      REG_SHIFT_X: prdata = 64'(cfg.shift[0]);
      REG_SHIFT_Y: prdata = 64'(cfg.shift[1]);
      REG_SHIFT_Z: prdata = 64'(cfg.shift[2]);
      default:     prdata = '0;
    endcase
  end

endmodule

// File: hdl/aabb_mul_stage.sv
// Pipeline stage 1: all nine coefficients times both bounds of each axis.
// Depends on aabb_pkg.
`timescale 1ns / 1ps

module aabb_mul_stage
  import aabb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  box_t      in_box,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_set_t out_prod
);

  prod_set_t prod_next;

  // 18 signed 16x24 multipliers
  for (genvar j = 0; j < AXES; j++) begin : g_out_axis
    for (genvar k = 0; k < AXES; k++) begin : g_in_axis
      logic signed [COEF_W-1:0]  c;
      logic signed [COORD_W-1:0] lo, hi;
      assign c  = cfg.row[j][k*COEF_W +: COEF_W];
      assign lo = in_box.lo[k];
      assign hi = in_box.hi[k];
      assign prod_next.lo[j][k] = PROD_W'(c * lo);
      assign prod_next.hi[j][k] = PROD_W'(c * hi);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_prod <= prod_next;
    end
  end

endmodule

// File: hdl/aabb_span_stage.sv
// Pipeline stages 2 and 3: per-term min/max, then the extreme sums per axis.
// Depends on aabb_pkg. The extreme corner is picked one term at a time.
`timescale 1ns / 1ps

module aabb_span_stage
  import aabb_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_set_t in_prod,
  output logic      out_valid,
  input  logic      out_ready,
  output acc_span_t out_span
);

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  logic      term_valid;
  logic      term_ready;
  prod_set_t term;       // lo holds the smaller term, hi the larger
  prod_set_t term_next;
  acc_span_t span_next;

  // Stage 2: order each product pair
  for (genvar j = 0; j < AXES; j++) begin : g_term_j
    for (genvar k = 0; k < AXES; k++) begin : g_term_k
      logic swap;
      assign swap = $signed(in_prod.hi[j][k]) < $signed(in_prod.lo[j][k]);
      assign term_next.lo[j][k] = swap ? in_prod.hi[j][k] : in_prod.lo[j][k];
      assign term_next.hi[j][k] = swap ? in_prod.lo[j][k] : in_prod.hi[j][k];
    end
  end

  assign in_ready = !term_valid || term_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (in_ready) begin
      term_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      term <= term_next;
    end
  end

  // Stage 3: sum the three chosen terms and add the rounding offset
  for (genvar j = 0; j < AXES; j++) begin : g_sum
    assign span_next.amin[j] = ACC_W'($signed(term.lo[j][0])) + ACC_W'($signed(term.lo[j][1]))
                             + ACC_W'($signed(term.lo[j][2])) + HALF;
    assign span_next.amax[j] = ACC_W'($signed(term.hi[j][0])) + ACC_W'($signed(term.hi[j][1]))
                             + ACC_W'($signed(term.hi[j][2])) + HALF;
  end

  assign term_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (term_ready) begin
      out_valid <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term_ready && term_valid) begin
      out_span <= span_next;
    end
  end

endmodule

// File: hdl/aabb_clamp_stage.sv
// Pipeline stage 4: drop fraction bits, add translation, saturate.
// Depends on aabb_pkg. Holds the output register of the block.
`timescale 1ns / 1ps

module aabb_clamp_stage
  import aabb_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  acc_span_t                    in_span,
  input  cfg_t                         cfg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output box_t                         out_box,
  output logic                         out_sat
);

  box_t                 box_next;
  logic [2*AXES-1:0]    clip;

  // Floor shift and clamp are monotonic, so the extremes stay extremes
  for (genvar a = 0; a < 2 * AXES; a++) begin : g_clamp
    localparam int AX = a % AXES;
    logic signed [ACC_W-1:0] acc;
    logic signed [VAL_W-1:0] val;
    logic                    over, under;
    assign acc   = (a < AXES) ? $signed(in_span.amin[AX]) : $signed(in_span.amax[AX]);
    assign val   = VAL_W'(acc >>> COEF_FRAC_BITS) + VAL_W'($signed(cfg.shift[AX]));
    assign over  = val > VAL_W'(COORD_MAX);
    assign under = val < VAL_W'(COORD_MIN);
    assign clip[a] = over || under;
    if (a < AXES) begin : g_lo
      assign box_next.lo[AX] = over ? COORD_MAX : (under ? COORD_MIN : val[COORD_W-1:0]);
    end else begin : g_hi
      assign box_next.hi[AX] = over ? COORD_MAX : (under ? COORD_MIN : val[COORD_W-1:0]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_box <= box_next;
      out_sat <= |clip;
    end
  end

endmodule

// File: hdl/aabb_affine_transform_bounds_unit.sv
// Top level: affine transform of an axis-aligned box, four-stage pipeline.
// Depends on aabb_pkg, aabb_cfg_regs, aabb_mul_stage, aabb_span_stage, aabb_clamp_stage.
//
//   channel   dir  handshake              payload
//   s_axis    in   s_tvalid / s_tready    s_tdata: input box, 144 bits
//   m_axis    out  m_tvalid / m_tready    m_tdata: result box, m_tuser: saturated
//   apb       in   psel/penable/pready    paddr, pwdata, prdata (64 bits)
//
// One box per cycle sustained while m_tready holds; each box passes through the multiply,
// term order, sum and clamp registers in turn. Each stage loads whenever its own register
// is empty or its successor loads, so bubbles collapse under stall.
// rst (synchronous) empties the pipeline and loads the identity map.
`timescale 1ns / 1ps

module aabb_affine_transform_bounds_unit
  import aabb_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  // input box beat
  input  logic         s_tvalid,
  output logic         s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [143:0] s_tdata,
  // result box beat
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
  output logic [143:0] m_tdata,
  // saturated
  output logic         m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  cfg_t      cfg;
  prod_set_t prod;
  acc_span_t span;
  box_t      res_box;
  logic      mul_valid, mul_ready;
  logic      span_valid, span_ready;

  assign pready = 1'b1;

  aabb_cfg_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  aabb_mul_stage u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_box   (box_t'(s_tdata)),
    .cfg      (cfg),
    .out_valid(mul_valid),
    .out_ready(mul_ready),
    .out_prod (prod)
  );

  aabb_span_stage #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_span (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mul_valid),
    .in_ready (mul_ready),
    .in_prod  (prod),
    .out_valid(span_valid),
    .out_ready(span_ready),
    .out_span (span)
  );

  aabb_clamp_stage #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_clamp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (span_valid),
    .in_ready (span_ready),
    .in_span  (span),
    .cfg      (cfg),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_box  (res_box),
    .out_sat  (m_tuser)
  );

  assign m_tdata = res_box;

  // Checks
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> mul_valid)
    else $error("accepted box did not enter the multiply stage");

  a_order_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(res_box.lo[0]) <= $signed(res_box.hi[0]))
    else $error("x bounds out of order");

  a_order_yz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(res_box.lo[1]) <= $signed(res_box.hi[1]))
              && ($signed(res_box.lo[2]) <= $signed(res_box.hi[2])))
    else $error("y or z bounds out of order");

endmodule
